[hw/rtl/ocedf_pkg.sv]
`default_nettype none

package ocedf_pkg;

    // Framing constants
    localparam int PREAMBLE_BYTES = 7;
    localparam int SEQ_WIDTH      = 16;
    localparam int PS_WIDTH       = $clog2(PREAMBLE_BYTES + 16);

    localparam logic [7:0] PREAMBLE_MARK = 8'hAA;
    localparam logic [7:0] SFD_MARK      = 8'hAB;

    // Parser positions; the preamble occupies positions 0 .. PREAMBLE_BYTES-1
    localparam logic [PS_WIDTH-1:0] ST_IDLE    = '0;
    localparam logic [PS_WIDTH-1:0] ST_SFD     = PS_WIDTH'(PREAMBLE_BYTES);
    localparam logic [PS_WIDTH-1:0] ST_SRC     = PS_WIDTH'(PREAMBLE_BYTES + 7);
    localparam logic [PS_WIDTH-1:0] ST_LEN_LO  = PS_WIDTH'(PREAMBLE_BYTES + 13);
    localparam logic [PS_WIDTH-1:0] ST_LEN_HI  = PS_WIDTH'(PREAMBLE_BYTES + 14);
    localparam logic [PS_WIDTH-1:0] ST_PAYLOAD = PS_WIDTH'(PREAMBLE_BYTES + 15);

    localparam logic [15:0] LENGTH_RESET = 16'd20;

    typedef struct packed {
        logic [PS_WIDTH-1:0] state;
        logic [47:0]         dest;
        logic [47:0]         src;
        logic [15:0]         len;
        logic [15:0]         seen;
    } parser_state_t;

    typedef struct packed {
        logic emit;
        logic header_done;
        logic frame_done;
    } parse_event_t;

    typedef struct packed {
        logic gap;
        logic repeat_seen;
    } seq_flags_t;

endpackage

`default_nettype wire

[hw/rtl/ocedf_seq_check.sv]
`default_nettype none

module ocedf_seq_check (
    input  wire logic [ocedf_pkg::SEQ_WIDTH-1:0] seq_count,
    input  wire logic [ocedf_pkg::SEQ_WIDTH-1:0] prev_count,
    input  wire ocedf_pkg::seq_flags_t           flags_cur,
    output ocedf_pkg::seq_flags_t                flags_next
);
    import ocedf_pkg::*;

    logic [SEQ_WIDTH:0] prev_plus_one;

    assign prev_plus_one = {1'b0, prev_count} + (SEQ_WIDTH + 1)'(1);

    always_comb begin
        flags_next = flags_cur;
        if (seq_count == prev_plus_one[SEQ_WIDTH-1:0]) begin
            flags_next = '0;
        end else if ({1'b0, seq_count} > prev_plus_one) begin
            flags_next.gap = 1'b1;
        end else if (seq_count == prev_count) begin
            flags_next.repeat_seen = 1'b1;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ocedf_byte_parser.sv]
`default_nettype none

module ocedf_byte_parser (
    input  wire logic [7:0]              data,
    input  wire ocedf_pkg::parser_state_t cur,
    output ocedf_pkg::parser_state_t      nxt,
    output ocedf_pkg::parse_event_t       ev
);
    import ocedf_pkg::*;

    always_comb begin
        nxt = cur;
        ev  = '0;
        if (cur.state < ST_SFD) begin
            if (data == PREAMBLE_MARK) begin
                nxt.state = cur.state + PS_WIDTH'(1);
            end
        end else if (cur.state == ST_SFD) begin
            if (data == SFD_MARK) begin
                nxt.state = cur.state + PS_WIDTH'(1);
            end
        end else if (cur.state < ST_SRC) begin
            nxt.dest  = {cur.dest[39:0], data};
            nxt.state = cur.state + PS_WIDTH'(1);
        end else if (cur.state < ST_LEN_LO) begin
            nxt.src   = {cur.src[39:0], data};
            nxt.state = cur.state + PS_WIDTH'(1);
        end else if (cur.state == ST_LEN_LO) begin
            nxt.len   = {cur.len[15:8], data};
            nxt.state = cur.state + PS_WIDTH'(1);
        end else if (cur.state == ST_LEN_HI) begin
            nxt.len        = {data, cur.len[7:0]};
            ev.header_done = 1'b1;
            nxt.state      = cur.state + PS_WIDTH'(1);
        end else if (cur.state == ST_PAYLOAD) begin
            if (cur.seen < cur.len) begin
                ev.emit  = 1'b1;
                nxt.seen = cur.seen + 16'd1;
            end else begin
                // drop the trailing byte and close the frame
                nxt.seen      = '0;
                ev.frame_done = 1'b1;
                nxt.state     = ST_IDLE;
            end
        end else begin
            nxt.state = ST_IDLE;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/overhead_channel_ethernet_deframer_core.sv]
// A poll passes the input register, then the result register, to the master side.
// Throughput: 1 poll per cycle while m_tready is high; the input register and the
//   result register each advance whenever the stage after them is empty or draining.
// Reset (aresetn low, synchronous): both pipeline stages empty, sequence flags
//   and count cleared, parser back to preamble search, length reloaded to 20.
`default_nettype none

module overhead_channel_ethernet_deframer_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [15:0] seq_count, [23:16] first_byte, [31:24] second_byte
    input  wire logic [31:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [0] loss_flag, [1] repeat_flag, [3:2] payload_valid_count,
    // [11:4] payload_first, [19:12] payload_second, [20] header_done,
    // [68:21] dest_mac, [116:69] source_mac, [132:117] frame_length, [135:133] zero
    output logic [135:0]      m_tdata,
    // frame_done: payload finished during this poll
    output logic              m_tlast
);
    import ocedf_pkg::*;

    // Input register stage
    logic                 in_valid_reg, in_valid_next;
    logic [SEQ_WIDTH-1:0] in_seq_reg;
    logic [7:0]           in_first_reg;
    logic [7:0]           in_second_reg;

    // Persistent state
    logic [SEQ_WIDTH-1:0] prev_count_reg, prev_count_next;
    seq_flags_t           flags_reg, flags_next;
    parser_state_t        parser_reg, parser_next;

    // Result register stage
    logic                 out_valid_reg, out_valid_next;
    logic [135:0]         out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    logic                 advance;
    logic                 parse_ok;
    parser_state_t        mid_state, end_state;
    parse_event_t         ev_first, ev_second;
    logic [1:0]           pay_count;
    logic [7:0]           pay_first, pay_second;
    logic                 hdr_done, frm_done;

    // Move a poll from the input register into the result register when the
    // result slot is empty or is being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ocedf_seq_check u_seq_check (
        .seq_count  (in_seq_reg),
        .prev_count (prev_count_reg),
        .flags_cur  (flags_reg),
        .flags_next (flags_next)
    );

    // Two parser steps chained: first byte, then second byte
    ocedf_byte_parser u_parse_first (
        .data (in_first_reg),
        .cur  (parser_reg),
        .nxt  (mid_state),
        .ev   (ev_first)
    );

    ocedf_byte_parser u_parse_second (
        .data (in_second_reg),
        .cur  (mid_state),
        .nxt  (end_state),
        .ev   (ev_second)
    );

    // Parse only while neither sticky flag is set after this poll's check
    assign parse_ok = !flags_next.gap && !flags_next.repeat_seen;

    always_comb begin
        hdr_done   = parse_ok && (ev_first.header_done || ev_second.header_done);
        frm_done   = parse_ok && (ev_first.frame_done || ev_second.frame_done);
        pay_count  = 2'd0;
        pay_first  = '0;
        pay_second = '0;
        if (parse_ok) begin
            pay_count = {1'b0, ev_first.emit} + {1'b0, ev_second.emit};
            // pack delivered bytes toward the first slot
            if (ev_first.emit) begin
                pay_first = in_first_reg;
                if (ev_second.emit) begin
                    pay_second = in_second_reg;
                end
            end else if (ev_second.emit) begin
                pay_first = in_second_reg;
            end
        end
    end

    always_comb begin
        in_valid_next   = in_valid_reg;
        prev_count_next = prev_count_reg;
        parser_next     = parser_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        // drain the result register on a master transfer
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            in_valid_next   = 1'b0;
            prev_count_next = in_seq_reg;
            if (parse_ok) begin
                parser_next = end_state;
            end
            out_valid_next = 1'b1;
            out_last_next  = frm_done;
            out_data_next  = {3'b000,
                              (parse_ok ? end_state.len  : parser_reg.len),
                              (parse_ok ? end_state.src  : parser_reg.src),
                              (parse_ok ? end_state.dest : parser_reg.dest),
                              hdr_done, pay_second, pay_first, pay_count,
                              flags_next.repeat_seen, flags_next.gap};
        end
        // hold a new poll in the input register
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_count_reg <= '0;
            flags_reg      <= '0;
            parser_reg     <= '{state: ST_IDLE, dest: '0, src: '0,
                                len: LENGTH_RESET, seen: '0};
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            prev_count_reg <= prev_count_next;
            parser_reg     <= parser_next;
            if (advance) begin
                flags_reg <= flags_next;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_seq_reg    <= s_tdata[SEQ_WIDTH-1:0];
            in_first_reg  <= s_tdata[23:16];
            in_second_reg <= s_tdata[31:24];
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Two parser steps cannot deliver more than two payload bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:2] != 2'd3))
        else $error("payload count out of range");

    // A frame can only close on a poll that was parsed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (!m_tdata[0] && !m_tdata[1]))
        else $error("frame closed with a sticky flag set");

    // The parser never leaves its defined range of positions
    assert property (@(posedge aclk) disable iff (!aresetn)
        parser_reg.state <= ST_PAYLOAD)
        else $error("parser position out of range");

    // A result stalled by the sink must not be overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> $stable(out_data_reg))
        else $error("stalled result changed");

endmodule

`default_nettype wire

[sim/tb_overhead_channel_ethernet_deframer_core.sv]
`timescale 1ns / 100ps

module tb_overhead_channel_ethernet_deframer_core;

    import ocedf_pkg::*;

    localparam int RANDOM_POLLS = 1450;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 300;

    // Result word as it sits on m_tdata, lowest field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] frame_length;
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic        header_done;
        logic [7:0]  payload_second;
        logic [7:0]  payload_first;
        logic [1:0]  payload_valid_count;
        logic        repeat_flag;
        logic        loss_flag;
    } poll_word_t;

    typedef struct {
        poll_word_t word;
        logic       frame_done;
    } poll_expect_t;

    // One directed poll; where typed is set the result fields below are the
    // expected result (payload fields zero), otherwise the predictor decides.
    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic        typed;
        logic        loss;
        logic        rpt;
        logic        hdr;
        logic        fin;
        logic [47:0] dst;
        logic [47:0] src;
        logic [15:0] len;
    } poll_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tlast;

    overhead_channel_ethernet_deframer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Predictor state: sequence check, sticky flags and byte parser
    logic [15:0]         seq_prev;
    logic                loss_q;
    logic                repeat_q;
    logic [PS_WIDTH-1:0] parse_pos;
    logic [47:0]         dest_q;
    logic [47:0]         src_q;
    logic [15:0]         len_q;
    logic [15:0]         seen_q;
    poll_expect_t        poll_now;

    poll_expect_t expected_polls[$];
    logic [7:0]   byte_stream[$];

    int mismatches     = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 25;
    int sink_idle_pct  = 25;
    int hold_requests  = 0;

    // Directed polls: sequence corner cases first, then a zero-length frame
    // with an all-ones destination and an all-zeros source, then a short frame.
    poll_row_t directed_rows [30] = '{
        // after reset: count one above zero, bytes are no preamble
        '{'h0001, 'h00, 'h00, 1, 0, 0, 0, 0, 0, 0, 20},
        // same count again: repeat, bytes ignored
        '{'h0001, 'hAA, 'hAA, 1, 0, 1, 0, 0, 0, 0, 20},
        // far jump: loss, repeat stays
        '{'hFFFF, 'hAA, 'hAA, 1, 1, 1, 0, 0, 0, 0, 20},
        // wrap to zero is the successor: both flags clear, parse resumes
        '{'h0000, 'hAA, 'hAA, 1, 0, 0, 0, 0, 0, 0, 20},
        '{'h0001, 'hAA, 'hAA, 1, 0, 0, 0, 0, 0, 0, 20},
        '{'h7FFF, 'hAA, 'hAA, 1, 1, 0, 0, 0, 0, 0, 20},
        // lower count: no flag changes
        '{'h0005, 'hAA, 'hAA, 1, 1, 0, 0, 0, 0, 0, 20},
        '{'h0006, 'hAA, 'hAA, 1, 0, 0, 0, 0, 0, 0, 20},
        // mismatching byte at the start-of-frame position holds
        '{'h0007, 'hAA, 'h55, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0008, 'hAB, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0009, 'hFF, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h000A, 'hFF, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h000B, 'hFF, 'h00, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h000C, 'h00, 'h00, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h000D, 'h00, 'h00, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h000E, 'h00, 'h00, 0, 0, 0, 0, 0, 0, 0, 0},
        // zero length: header done, next byte dropped and the frame ends
        '{'h000F, 'h00, 'hAA, 1, 0, 0, 1, 1, 48'hFFFF_FFFF_FFFF, 0, 0},
        '{'h0010, 'hAA, 'hAA, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0011, 'hAA, 'hAA, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0012, 'hAA, 'hAA, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0013, 'hAA, 'hAB, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0014, 'h00, 'h11, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0015, 'h22, 'h33, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0016, 'h44, 'h55, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0017, 'hFF, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0018, 'hFF, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h0019, 'hFF, 'hFF, 0, 0, 0, 0, 0, 0, 0, 0},
        // length three, then two payload bytes, then one plus the end
        '{'h001A, 'h03, 'h00, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h001B, 'h5A, 'hA5, 0, 0, 0, 0, 0, 0, 0, 0},
        '{'h001C, 'h7E, 'h99, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    function void deframer_reset();
        seq_prev  = '0;
        loss_q    = 1'b0;
        repeat_q  = 1'b0;
        parse_pos = ST_IDLE;
        dest_q    = '0;
        src_q     = '0;
        len_q     = LENGTH_RESET;
        seen_q    = '0;
    endfunction

    // Update the sticky flags for a new count; return whether the bytes parse
    function automatic bit seq_advance(logic [15:0] seq);
        logic [16:0] succ;
        succ = {1'b0, seq_prev} + 17'd1;
        if (seq == succ[15:0]) begin
            loss_q   = 1'b0;
            repeat_q = 1'b0;
        end else if ({1'b0, seq} > succ) begin
            loss_q = 1'b1;
        end else if (seq == seq_prev) begin
            repeat_q = 1'b1;
        end
        seq_prev = seq;
        return !loss_q && !repeat_q;
    endfunction

    function void deframe_byte(logic [7:0] b);
        if (parse_pos < ST_SFD) begin
            if (b == PREAMBLE_MARK) parse_pos = parse_pos + 1'b1;
        end else if (parse_pos == ST_SFD) begin
            if (b == SFD_MARK) parse_pos = parse_pos + 1'b1;
        end else if (parse_pos < ST_SRC) begin
            dest_q    = {dest_q[39:0], b};
            parse_pos = parse_pos + 1'b1;
        end else if (parse_pos < ST_LEN_LO) begin
            src_q     = {src_q[39:0], b};
            parse_pos = parse_pos + 1'b1;
        end else if (parse_pos == ST_LEN_LO) begin
            len_q[7:0] = b;
            parse_pos  = parse_pos + 1'b1;
        end else if (parse_pos == ST_LEN_HI) begin
            len_q[15:8]               = b;
            poll_now.word.header_done = 1'b1;
            parse_pos                 = parse_pos + 1'b1;
        end else if (parse_pos == ST_PAYLOAD) begin
            if (seen_q < len_q) begin
                if (poll_now.word.payload_valid_count == 2'd0)
                    poll_now.word.payload_first = b;
                else if (poll_now.word.payload_valid_count == 2'd1)
                    poll_now.word.payload_second = b;
                poll_now.word.payload_valid_count = poll_now.word.payload_valid_count + 1'b1;
                seen_q = seen_q + 16'd1;
            end else begin
                // trailing byte: drop it and close the frame
                seen_q              = '0;
                poll_now.frame_done = 1'b1;
                parse_pos           = ST_IDLE;
            end
        end else begin
            parse_pos = ST_IDLE;
        end
    endfunction

    function void deframe_pair(bit parsing, logic [7:0] b0, logic [7:0] b1);
        poll_now.word       = '0;
        poll_now.frame_done = 1'b0;
        if (parsing) begin
            deframe_byte(b0);
            deframe_byte(b1);
        end
        poll_now.word.loss_flag    = loss_q;
        poll_now.word.repeat_flag  = repeat_q;
        poll_now.word.dest_mac     = dest_q;
        poll_now.word.source_mac   = src_q;
        poll_now.word.frame_length = len_q;
    endfunction

    // Mostly the successor count; now and then a repeat, a gap, a step back
    // or a wild jump
    function automatic logic [15:0] pick_seq();
        int roll;
        roll = $urandom_range(99);
        if (roll < 93) return seq_prev + 16'd1;
        else if (roll < 95) return seq_prev;
        else if (roll < 97) return seq_prev + 16'($urandom_range(2, 6));
        else if (roll < 98) return seq_prev - 16'($urandom_range(1, 300));
        else return 16'($urandom);
    endfunction

    // Append one well-formed frame with random content, sometimes with stray
    // bytes in the preamble, or a burst of noise with no frame at all
    function void queue_frame();
        int          n;
        logic [7:0]  b;
        logic [15:0] len;
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(2, 10);
            repeat (n) byte_stream.push_back(8'($urandom));
            return;
        end
        n = $urandom_range(0, 2);
        repeat (n) byte_stream.push_back(8'($urandom));
        for (int k = 0; k < PREAMBLE_BYTES; k++) begin
            if ($urandom_range(15) == 0) begin
                b = 8'($urandom);
                if (b == PREAMBLE_MARK) b = 8'h00;
                byte_stream.push_back(b);
            end
            byte_stream.push_back(PREAMBLE_MARK);
        end
        if ($urandom_range(3) == 0) begin
            b = 8'($urandom);
            if (b == SFD_MARK) b = 8'h00;
            byte_stream.push_back(b);
        end
        byte_stream.push_back(SFD_MARK);
        repeat (12) byte_stream.push_back(8'($urandom));
        if ($urandom_range(19) == 0) len = 16'($urandom_range(13, 300));
        else len = 16'($urandom_range(0, 12));
        byte_stream.push_back(len[7:0]);
        byte_stream.push_back(len[15:8]);
        repeat (len) byte_stream.push_back(8'($urandom));
        byte_stream.push_back(8'($urandom));
    endfunction

    function automatic logic [7:0] take_byte();
        if (byte_stream.size() == 0) queue_frame();
        return byte_stream.pop_front();
    endfunction

    function void check_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one poll; idle at random before it, record the prediction once
    // the transfer happens
    task automatic offer_poll(logic [31:0] word, poll_expect_t want);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_polls.push_back(want);
    endtask

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus
    // asks for one, so the pipeline fills and stalls its input
    initial begin : result_sink
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        m_tready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_check
        poll_word_t   got;
        poll_expect_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_polls.size() == 0) begin
                $error("result transfer with no poll outstanding");
                mismatches++;
            end else begin
                want = expected_polls.pop_front();
                check_field("loss_flag", want.word.loss_flag, got.loss_flag);
                check_field("repeat_flag", want.word.repeat_flag, got.repeat_flag);
                check_field("payload_valid_count", want.word.payload_valid_count,
                            got.payload_valid_count);
                check_field("payload_first", want.word.payload_first, got.payload_first);
                check_field("payload_second", want.word.payload_second, got.payload_second);
                check_field("header_done", want.word.header_done, got.header_done);
                check_field("frame_done", want.frame_done, m_tlast);
                check_field("dest_mac", want.word.dest_mac, got.dest_mac);
                check_field("source_mac", want.word.source_mac, got.source_mac);
                check_field("frame_length", want.word.frame_length, got.frame_length);
            end
        end
    end

    initial begin : stimulus
        poll_row_t   row;
        bit          parsing;
        logic [15:0] seq;
        logic [7:0]  b0;
        logic [7:0]  b1;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        deframer_reset();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table; typed rows replace the prediction, the predictor
        // still advances so later rows stay in step
        for (int r = 0; r < $size(directed_rows); r++) begin
            row     = directed_rows[r];
            parsing = seq_advance(row.seq);
            deframe_pair(parsing, row.b0, row.b1);
            if (row.typed) begin
                poll_now.word              = '0;
                poll_now.word.loss_flag    = row.loss;
                poll_now.word.repeat_flag  = row.rpt;
                poll_now.word.header_done  = row.hdr;
                poll_now.word.dest_mac     = row.dst;
                poll_now.word.source_mac   = row.src;
                poll_now.word.frame_length = row.len;
                poll_now.frame_done        = row.fin;
            end
            offer_poll({row.b1, row.b0, row.seq}, poll_now);
        end

        // Pause the sender until the block has drained
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_polls.size() != 0) @(posedge aclk);

        // Random frames: start with a stretch at full rate on both sides,
        // then random idling, with one long receiver hold-off partway in
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int i = 0; i < RANDOM_POLLS; i++) begin
            if (i == 350) begin
                src_idle_pct  = 25;
                sink_idle_pct = 25;
            end
            if (i == 700) hold_requests++;
            seq     = pick_seq();
            parsing = seq_advance(seq);
            // keep the frame stream aligned: only parsed polls consume it
            if (parsing) begin
                b0 = take_byte();
                b1 = take_byte();
            end else begin
                b0 = 8'($urandom);
                b1 = 8'($urandom);
            end
            deframe_pair(parsing, b0, b1);
            offer_poll({b1, b0, seq}, poll_now);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_polls.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[overhead_channel_ethernet_deframer_core.f]
hw/rtl/ocedf_pkg.sv
hw/rtl/ocedf_seq_check.sv
hw/rtl/ocedf_byte_parser.sv
hw/rtl/overhead_channel_ethernet_deframer_core.sv
sim/tb_overhead_channel_ethernet_deframer_core.sv
